FILE: rtl/core/nipl_pkg.sv
// Shared types and constants of the NAND image page locator.
package nipl_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned IN_PAGE_W  = 24;
  localparam int unsigned OUT_PAGE_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES_PER_BLOCK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT     = 2'd2;

  localparam logic [3:0]  SHIFT_MIN       = 4'd9;
  localparam logic [3:0]  SHIFT_MAX       = 4'd14;
  localparam logic [3:0]  RST_PAGE_SHIFT  = 4'd11;
  localparam logic [10:0] RST_PPB         = 11'd64;
  localparam logic [7:0]  RST_RETRY_LIMIT = 8'd32;
  localparam logic [15:0] TAG_MASK        = 16'hffff;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_PAGE  = 1'b1;

  typedef enum logic [1:0] {
    KIND_REQ  = 2'd0,
    KIND_DONE = 2'd1,
    KIND_FAIL = 2'd2,
    KIND_IGN  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [3:0]  eff_shift;
    logic [10:0] block_pages;
    logic [7:0]  retry_limit;
  } cfg_t;

  typedef struct packed {
    logic                 cmd;
    logic [IN_PAGE_W-1:0] start_page;
    logic [31:0]          dest_base;
    logic [31:0]          length_bytes;
    logic [15:0]          first_tag_count;
    logic [7:0]           magic_byte;
    logic                 ecc_fail;
    logic [31:0]          spare_word;
  } item_t;

  typedef struct packed {
    kind_t                 kind;
    logic [OUT_PAGE_W-1:0] flash_page;
    logic [31:0]           mem_addr;
  } res_t;

endpackage

FILE: rtl/core/nipl_cfg.sv
// Configuration registers with page shift clamping.
module nipl_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [nipl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nipl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output nipl_pkg::cfg_t                   cfg
);

  logic [3:0]  page_shift_r;
  logic [10:0] ppb_r;
  logic [7:0]  retry_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_shift_r  <= nipl_pkg::RST_PAGE_SHIFT;
      ppb_r         <= nipl_pkg::RST_PPB;
      retry_limit_r <= nipl_pkg::RST_RETRY_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        nipl_pkg::CFG_PAGE_SHIFT:      page_shift_r  <= cfg_wdata[3:0];
        nipl_pkg::CFG_PAGES_PER_BLOCK: ppb_r         <= cfg_wdata;
        nipl_pkg::CFG_RETRY_LIMIT:     retry_limit_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (page_shift_r < nipl_pkg::SHIFT_MIN) begin
      cfg.eff_shift = nipl_pkg::SHIFT_MIN;
    end else if (page_shift_r > nipl_pkg::SHIFT_MAX) begin
      cfg.eff_shift = nipl_pkg::SHIFT_MAX;
    end else begin
      cfg.eff_shift = page_shift_r;
    end
    cfg.block_pages = ppb_r;
    cfg.retry_limit = retry_limit_r;
  end

endmodule

FILE: rtl/core/nipl_seq.sv
// Image read state and the per-item decision logic.
module nipl_seq #(
  parameter int unsigned PAGE_ADDR_BITS = 24
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_en,
  input  nipl_pkg::item_t item,
  input  nipl_pkg::cfg_t  cfg,
  output nipl_pkg::res_t  res
);

  logic                      busy_r, busy_nxt;
  logic [PAGE_ADDR_BITS-1:0] page_r, page_nxt;
  logic [23:0]               left_r, left_nxt;
  logic [31:0]               dest_r, dest_nxt;
  logic [15:0]               tag_r, tag_nxt;
  logic [7:0]                magic_r, magic_nxt;
  logic [7:0]                retry_r, retry_nxt;

  logic [32:0]               round_up;
  logic [23:0]               start_pages;
  logic [31:0]               page_bytes;
  logic [31:0]               expect_spare;
  logic                      page_ok;
  logic [PAGE_ADDR_BITS-1:0] load_page;
  logic [PAGE_ADDR_BITS-1:0] jump_addr;
  logic [PAGE_ADDR_BITS-1:0] step_addr;
  logic [31:0]               step_dest;
  logic [23:0]               left_dec;

  always_comb begin
    round_up     = {1'b0, item.length_bytes} + ((33'd1 << cfg.eff_shift) - 33'd1);
    start_pages  = 24'(round_up >> cfg.eff_shift);
    page_bytes   = 32'd1 << cfg.eff_shift;
    expect_spare = {tag_r, 8'h00, magic_r};
    page_ok      = !item.ecc_fail && (item.spare_word == expect_spare);
    load_page    = PAGE_ADDR_BITS'(item.start_page);
    jump_addr    = page_r + PAGE_ADDR_BITS'(cfg.block_pages);
    step_addr    = page_r + PAGE_ADDR_BITS'(1);
    step_dest    = dest_r + page_bytes;
    left_dec     = left_r - 24'd1;
  end

  always_comb begin
    busy_nxt  = busy_r;
    page_nxt  = page_r;
    left_nxt  = left_r;
    dest_nxt  = dest_r;
    tag_nxt   = tag_r;
    magic_nxt = magic_r;
    retry_nxt = retry_r;
    res.kind       = nipl_pkg::KIND_IGN;
    res.flash_page = '0;
    res.mem_addr   = '0;
    case (item.cmd)
      nipl_pkg::CMD_START: begin
        page_nxt  = load_page;
        dest_nxt  = item.dest_base;
        tag_nxt   = item.first_tag_count & nipl_pkg::TAG_MASK;
        magic_nxt = item.magic_byte;
        retry_nxt = cfg.retry_limit;
        left_nxt  = start_pages;
        busy_nxt  = (start_pages != 24'd0);
        res.kind       = (start_pages != 24'd0) ? nipl_pkg::KIND_REQ : nipl_pkg::KIND_DONE;
        res.flash_page = nipl_pkg::OUT_PAGE_W'(load_page);
        res.mem_addr   = item.dest_base;
      end
      nipl_pkg::CMD_PAGE: begin
        if (busy_r && !page_ok) begin
          if (retry_r <= 8'd1) begin
            // Budget spent: stop on the page that failed.
            retry_nxt      = 8'd0;
            busy_nxt       = 1'b0;
            res.kind       = nipl_pkg::KIND_FAIL;
            res.flash_page = nipl_pkg::OUT_PAGE_W'(page_r);
            res.mem_addr   = dest_r;
          end else begin
            // Try the same offset one erase block on.
            retry_nxt      = retry_r - 8'd1;
            page_nxt       = jump_addr;
            res.kind       = nipl_pkg::KIND_REQ;
            res.flash_page = nipl_pkg::OUT_PAGE_W'(jump_addr);
            res.mem_addr   = dest_r;
          end
        end else if (busy_r) begin
          page_nxt       = step_addr;
          dest_nxt       = step_dest;
          tag_nxt        = tag_r + 16'd1;
          left_nxt       = left_dec;
          busy_nxt       = (left_dec != 24'd0);
          res.kind       = (left_dec != 24'd0) ? nipl_pkg::KIND_REQ : nipl_pkg::KIND_DONE;
          res.flash_page = nipl_pkg::OUT_PAGE_W'(step_addr);
          res.mem_addr   = step_dest;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      page_r  <= '0;
      left_r  <= '0;
      dest_r  <= '0;
      tag_r   <= '0;
      magic_r <= '0;
      retry_r <= '0;
    end else if (step_en) begin
      busy_r  <= busy_nxt;
      page_r  <= page_nxt;
      left_r  <= left_nxt;
      dest_r  <= dest_nxt;
      tag_r   <= tag_nxt;
      magic_r <= magic_nxt;
      retry_r <= retry_nxt;
    end
  end

  a_fail_ends_read: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.kind == nipl_pkg::KIND_FAIL |=> !busy_r)
    else $error("read still busy after a failure");

  a_request_keeps_busy: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.kind == nipl_pkg::KIND_REQ |=> busy_r)
    else $error("read request issued but sequencer went idle");

  a_idle_page_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && !busy_r && item.cmd == nipl_pkg::CMD_PAGE |-> res.kind == nipl_pkg::KIND_IGN)
    else $error("page result while idle not ignored");

endmodule

FILE: rtl/core/nand_image_page_locator_core.sv
// Top level of the NAND image page locator: input and result registers.
// Path: input register, then result register; a stall on the result channel
//   can hold an item in the input register until the waiting result is taken.
// Throughput: one item per cycle while out_stall is low; the result register lets
//   the next item be taken while a result waits under out_stall.
// Reset (rst_n, synchronous, active low) empties both registers, goes idle
//   and restores page shift 11, 64 pages per block, retry limit 32.
module nand_image_page_locator_core #(
  parameter int unsigned PAGE_ADDR_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [nipl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nipl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_cmd,
  input  logic [23:0]                      in_start_page,
  input  logic [31:0]                      in_dest_base,
  input  logic [31:0]                      in_length_bytes,
  input  logic [15:0]                      in_first_tag_count,
  input  logic [7:0]                       in_magic_byte,
  input  logic                             in_ecc_fail,
  input  logic [31:0]                      in_spare_word,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_kind,
  output logic [23:0]                      out_flash_page,
  output logic [31:0]                      out_mem_addr
);

  nipl_pkg::cfg_t  cfg;
  nipl_pkg::item_t item_r;
  nipl_pkg::res_t  res;
  nipl_pkg::res_t  res_r;
  logic            item_valid_r, item_valid_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            advance;
  logic            step_en;
  logic            in_take;

  nipl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Decide the held item whenever the result register is free or being drained.
  assign advance  = !out_valid_r || !out_stall;
  assign step_en  = item_valid_r && advance;
  assign in_stall = item_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_take) begin
      item_valid_nxt = 1'b1;
    end else if (step_en) begin
      item_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step_en) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Capture the incoming item; payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.cmd             <= in_cmd;
      item_r.start_page      <= in_start_page;
      item_r.dest_base       <= in_dest_base;
      item_r.length_bytes    <= in_length_bytes;
      item_r.first_tag_count <= in_first_tag_count;
      item_r.magic_byte      <= in_magic_byte;
      item_r.ecc_fail        <= in_ecc_fail;
      item_r.spare_word      <= in_spare_word;
    end
  end

  nipl_seq #(
    .PAGE_ADDR_BITS (PAGE_ADDR_BITS)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Hold the result until taken.
  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = res_r.kind;
  assign out_flash_page = res_r.flash_page;
  assign out_mem_addr   = res_r.mem_addr;

  a_free_output_takes_item: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("input stalled while result register is empty");

  a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> out_valid_r)
    else $error("decided item produced no result");

  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind == nipl_pkg::KIND_IGN |-> out_flash_page == '0 && out_mem_addr == '0)
    else $error("ignored result carries nonzero addresses");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench of the NAND image page locator core.
`timescale 1ns / 1ps

module tb_top;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [nipl_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [nipl_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                            in_valid;
  logic                            in_stall;
  logic                            in_cmd;
  logic [23:0]                     in_start_page;
  logic [31:0]                     in_dest_base;
  logic [31:0]                     in_length_bytes;
  logic [15:0]                     in_first_tag_count;
  logic [7:0]                      in_magic_byte;
  logic                            in_ecc_fail;
  logic [31:0]                     in_spare_word;
  logic                            out_valid;
  logic                            out_stall;
  logic [1:0]                      out_kind;
  logic [23:0]                     out_flash_page;
  logic [31:0]                     out_mem_addr;

  nand_image_page_locator_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_start_page      (in_start_page),
    .in_dest_base       (in_dest_base),
    .in_length_bytes    (in_length_bytes),
    .in_first_tag_count (in_first_tag_count),
    .in_magic_byte      (in_magic_byte),
    .in_ecc_fail        (in_ecc_fail),
    .in_spare_word      (in_spare_word),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_flash_page     (out_flash_page),
    .out_mem_addr       (out_mem_addr)
  );

  // ---------------------------------------------------------------------------
  // Locator shadow: register copy and image-read state, advanced once per
  // accepted item. Everything here mirrors what the block holds after reset.
  // ---------------------------------------------------------------------------
  logic [3:0]  cfg_shift = nipl_pkg::RST_PAGE_SHIFT;
  logic [10:0] cfg_ppb   = nipl_pkg::RST_PPB;
  logic [7:0]  cfg_retry = nipl_pkg::RST_RETRY_LIMIT;

  logic        img_busy    = 1'b0;
  logic [23:0] cur_page    = '0;
  logic [23:0] pages_left  = '0;
  logic [31:0] dest_cursor = '0;
  logic [15:0] tag_count   = '0;
  logic [7:0]  img_magic   = '0;
  logic [7:0]  retries     = '0;

  // Page actions the block owes us, oldest first.
  nipl_pkg::res_t page_actions_q[$];
  int             mismatches = 0;
  int             burst_left = 0;

  // Clamp the programmed page shift into the supported 512 B .. 16 KiB range.
  function automatic logic [3:0] eff_page_shift();
    if (cfg_shift < nipl_pkg::SHIFT_MIN) return nipl_pkg::SHIFT_MIN;
    if (cfg_shift > nipl_pkg::SHIFT_MAX) return nipl_pkg::SHIFT_MAX;
    return cfg_shift;
  endfunction

  // Spare word that the page now awaited must carry to be accepted.
  function automatic logic [31:0] expected_spare();
    return {tag_count, 8'h00, img_magic};
  endfunction

  // Advance the shadow by one item and return the action the block must report.
  function automatic nipl_pkg::res_t next_page_action(nipl_pkg::item_t it);
    logic [3:0]     sh;
    logic [32:0]    n_pages;
    nipl_pkg::res_t r;
    sh = eff_page_shift();
    r.kind       = nipl_pkg::KIND_REQ;
    r.flash_page = '0;
    r.mem_addr   = '0;
    if (it.cmd == nipl_pkg::CMD_START) begin
      // Round the length up to whole pages; a restart drops any read in flight.
      n_pages     = ({1'b0, it.length_bytes} + ((33'd1 << sh) - 33'd1)) >> sh;
      cur_page    = it.start_page;
      dest_cursor = it.dest_base;
      tag_count   = it.first_tag_count;
      img_magic   = it.magic_byte;
      retries     = cfg_retry;
      pages_left  = n_pages[23:0];
      img_busy    = (pages_left != 0);
      r.kind      = img_busy ? nipl_pkg::KIND_REQ : nipl_pkg::KIND_DONE;
    end else if (!img_busy) begin
      // Stray page result: report it as ignored and leave the state alone.
      r.kind = nipl_pkg::KIND_IGN;
      return r;
    end else if (it.ecc_fail || it.spare_word != expected_spare()) begin
      // Bad page: spend one unit of the shared budget, or give up on the image.
      if (retries <= 8'd1) begin
        retries  = '0;
        img_busy = 1'b0;
        r.kind   = nipl_pkg::KIND_FAIL;
      end else begin
        retries  = retries - 8'd1;
        cur_page = cur_page + {13'd0, cfg_ppb};
      end
    end else begin
      // Good page: move on by one page in flash, memory and tag sequence.
      cur_page    = cur_page + 24'd1;
      dest_cursor = dest_cursor + (32'd1 << sh);
      tag_count   = tag_count + 16'd1;
      pages_left  = pages_left - 24'd1;
      if (pages_left == 0) begin
        img_busy = 1'b0;
        r.kind   = nipl_pkg::KIND_DONE;
      end
    end
    r.flash_page = cur_page;
    r.mem_addr   = dest_cursor;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders: fields a command does not use carry random noise.
  // ---------------------------------------------------------------------------
  function automatic nipl_pkg::item_t start_item(logic [23:0] page, logic [31:0] dest,
                                                 logic [31:0] len, logic [15:0] tag,
                                                 logic [7:0] magic);
    nipl_pkg::item_t it;
    it.cmd             = nipl_pkg::CMD_START;
    it.start_page      = page;
    it.dest_base       = dest;
    it.length_bytes    = len;
    it.first_tag_count = tag;
    it.magic_byte      = magic;
    it.ecc_fail        = 1'($urandom_range(0, 1));
    it.spare_word      = $urandom();
    return it;
  endfunction

  function automatic nipl_pkg::item_t page_item(logic ecc, logic [31:0] spare);
    nipl_pkg::item_t it;
    it.cmd             = nipl_pkg::CMD_PAGE;
    it.start_page      = 24'($urandom());
    it.dest_base       = $urandom();
    it.length_bytes    = $urandom();
    it.first_tag_count = 16'($urandom());
    it.magic_byte      = 8'($urandom());
    it.ecc_fail        = ecc;
    it.spare_word      = spare;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, limit and receiver stall pattern
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run; a correct run needs well under a tenth of this.
  initial begin
    #5_000_000;
    $display("nand_image_page_locator_core: mismatch");
    $finish;
  end

  // Receiver: pick a stall mode for a random stretch, including stretches of
  // no stall at all, light and heavy random stall, and long fixed stalls.
  int stall_mode = 0;
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left = stall_left - 1;
    case (stall_mode)
      0:       out_stall = 1'b0;
      1:       out_stall = ($urandom_range(0, 3) == 0);
      2:       out_stall = ($urandom_range(0, 3) != 0);
      default: out_stall = ((stall_left % 16) < 10);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare every accepted result with the oldest action owed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    nipl_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (page_actions_q.size() == 0) begin
        $error("result with nothing outstanding: kind %0d page %h dest %h",
               out_kind, out_flash_page, out_mem_addr);
        mismatches++;
      end else begin
        want = page_actions_q.pop_front();
        if (out_kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_kind);
          mismatches++;
        end
        if (out_flash_page !== want.flash_page) begin
          $error("flash_page: expected %h, got %h", want.flash_page, out_flash_page);
          mismatches++;
        end
        if (out_mem_addr !== want.mem_addr) begin
          $error("mem_addr: expected %h, got %h", want.mem_addr, out_mem_addr);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------------

  // Offer one item; hold it until accepted, then record the action it owes.
  // The sender works in bursts; between bursts drop valid for a random gap.
  task automatic send_item(nipl_pkg::item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left = burst_left - 1;
    @(negedge clk);
    in_valid           = 1'b1;
    in_cmd             = it.cmd;
    in_start_page      = it.start_page;
    in_dest_base       = it.dest_base;
    in_length_bytes    = it.length_bytes;
    in_first_tag_count = it.first_tag_count;
    in_magic_byte      = it.magic_byte;
    in_ecc_fail        = it.ecc_fail;
    in_spare_word      = it.spare_word;
    do @(posedge clk); while (in_stall);
    page_actions_q.push_back(next_page_action(it));
  endtask

  // Drop valid and wait until every owed result is in and the pipe is empty.
  task automatic settle_block();
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    while (page_actions_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [nipl_pkg::CFG_IDX_W-1:0] idx,
                           logic [nipl_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    case (idx)
      nipl_pkg::CFG_PAGE_SHIFT:      cfg_shift = val[3:0];
      nipl_pkg::CFG_PAGES_PER_BLOCK: cfg_ppb   = val[10:0];
      nipl_pkg::CFG_RETRY_LIMIT:     cfg_retry = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Reprogram the flash geometry and retry budget once the block is idle.
  task automatic program_geometry(logic [3:0] shift, logic [10:0] ppb,
                                  logic [7:0] retry);
    settle_block();
    write_reg(nipl_pkg::CFG_PAGE_SHIFT, {7'd0, shift});
    write_reg(nipl_pkg::CFG_PAGES_PER_BLOCK, ppb);
    write_reg(nipl_pkg::CFG_RETRY_LIMIT, {3'd0, retry});
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Page results before any image read are ignored.
  task automatic test_idle_page_results();
    send_item(page_item(1'b1, 32'hffff_ffff));
    send_item(page_item(1'b0, 32'h0000_0000));
  endtask

  // Zero length answers done at once; then an image that wraps the page
  // address, the destination and the tag counter, with ECC and tag failures.
  task automatic test_zero_length_and_wrap();
    send_item(start_item(24'hff_ffff, 32'hffff_ffff, 32'd0, 16'hffff, 8'hff));
    send_item(start_item(24'hff_ffff, 32'hffff_f800, 32'd4097, 16'hffff, 8'hff));
    send_item(page_item(1'b0, expected_spare()));
    send_item(page_item(1'b1, expected_spare()));
    send_item(page_item(1'b0, expected_spare() ^ 32'h0001_0000));
    send_item(page_item(1'b0, expected_spare()));
    send_item(page_item(1'b0, expected_spare()));
  endtask

  // A start while a read runs drops the old image; maximum length included.
  task automatic test_restart_while_busy();
    send_item(start_item(24'h00_0000, 32'h0000_0000, 32'hffff_ffff, 16'h0000, 8'h00));
    send_item(page_item(1'b0, expected_spare()));
    send_item(start_item(24'h12_3456, 32'h8000_0000, 32'd1, 16'h1234, 8'ha5));
    send_item(page_item(1'b0, expected_spare()));
  endtask

  // A zero budget acts as one; a zero block size retries the same page.
  task automatic test_retry_budget();
    program_geometry(4'd11, 11'd0, 8'd0);
    send_item(start_item(24'h00_0100, 32'h0000_1000, 32'd512, 16'h0007, 8'h3c));
    send_item(page_item(1'b1, expected_spare()));
    send_item(page_item(1'b0, 32'h5a5a_5a5a));
    program_geometry(4'd11, 11'd0, 8'd2);
    send_item(start_item(24'h00_0200, 32'h0000_2000, 32'd512, 16'h0009, 8'hc3));
    send_item(page_item(1'b0, ~expected_spare()));
    send_item(page_item(1'b0, expected_spare()));
  endtask

  // Shift values outside 9..14 clamp; the largest block size wraps the page.
  task automatic test_page_shift_clamp();
    program_geometry(4'd15, 11'd2047, 8'd2);
    send_item(start_item(24'hff_fff0, 32'h0001_0000, 32'd16385, 16'h0100, 8'h55));
    send_item(page_item(1'b0, expected_spare() ^ 32'h0000_0001));
    send_item(page_item(1'b1, expected_spare()));
    program_geometry(4'd0, 11'd64, 8'd32);
    send_item(start_item(24'h00_1000, 32'h0004_0000, 32'd513, 16'h0200, 8'haa));
    send_item(page_item(1'b0, expected_spare()));
    send_item(page_item(1'b0, expected_spare()));
  endtask

  // Mostly well-formed image reads with random content, plus restarts, bad
  // pages of every flavor and stray page results. Stray results are not
  // counted toward the item count.
  task automatic run_images(logic [3:0] shift, logic [10:0] ppb, logic [7:0] retry,
                            int n_items);
    int          sent;
    int          pick;
    logic [3:0]  sh;
    logic [23:0] page;
    logic [31:0] dest;
    logic [31:0] len;
    logic [15:0] tag;
    logic [31:0] good;
    program_geometry(shift, ppb, retry);
    sh   = eff_page_shift();
    sent = 0;
    while (sent < n_items) begin
      if (!img_busy && $urandom_range(0, 99) < 4) begin
        send_item(page_item(1'($urandom_range(0, 1)), $urandom()));
      end else if (!img_busy || $urandom_range(0, 99) < 4) begin
        page = 24'($urandom());
        if ($urandom_range(0, 3) == 0) page = 24'hff_ffff - 24'($urandom_range(0, 4));
        dest = $urandom();
        if ($urandom_range(0, 3) == 0) dest = 32'hffff_ffff - $urandom_range(0, 3 << sh);
        tag = 16'($urandom());
        if ($urandom_range(0, 3) == 0) tag = 16'hffff - 16'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 5)       len = 32'd0;
        else if (pick < 15) len = $urandom();
        else if (pick < 30) len = $urandom_range(1, 6) << sh;
        else                len = $urandom_range(1, 6 << sh);
        send_item(start_item(page, dest, len, tag, 8'($urandom())));
        sent++;
      end else begin
        good = expected_spare();
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          send_item(page_item(1'b0, good));
        end else begin
          case (pick % 4)
            0:       send_item(page_item(1'b1, good));
            1:       send_item(page_item(1'b1, $urandom()));
            2:       send_item(page_item(1'b0, good ^ (32'd1 << $urandom_range(0, 31))));
            default: send_item(page_item(1'b0, $urandom()));
          endcase
        end
        sent++;
      end
    end
  endtask

  task automatic test_random_images();
    run_images(4'd11, 11'd64, 8'd32, 85);
    run_images(4'd9, 11'd1, 8'd1, 85);
    run_images(4'd14, 11'd1024, 8'd255, 85);
    run_images(4'd0, 11'd0, 8'd3, 85);
    run_images(4'd15, 11'd2047, 8'd0, 85);
    run_images(4'd10, 11'd17, 8'd4, 85);
    run_images(4'd12, 11'd512, 8'd8, 85);
    run_images(4'($urandom_range(0, 15)), 11'($urandom_range(0, 2047)),
               8'($urandom_range(0, 255)), 85);
    run_images(4'($urandom_range(0, 15)), 11'($urandom_range(0, 2047)),
               8'($urandom_range(0, 255)), 85);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    in_valid           = 1'b0;
    in_cmd             = nipl_pkg::CMD_START;
    in_start_page      = '0;
    in_dest_base       = '0;
    in_length_bytes    = '0;
    in_first_tag_count = '0;
    in_magic_byte      = '0;
    in_ecc_fail        = 1'b0;
    in_spare_word      = '0;
    // Hold reset, then release it away from the sampling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_page_results();
    test_zero_length_and_wrap();
    test_restart_while_busy();
    test_retry_budget();
    test_page_shift_clamp();
    test_random_images();

    // Drain every owed result, then let the pipe run on before the verdict.
    settle_block();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("nand_image_page_locator_core: match");
    end else begin
      $display("nand_image_page_locator_core: mismatch");
    end
    $finish;
  end

endmodule
